>>> sv/ppid_pkg.sv
package ppid_pkg;

    // Default build values
    localparam int VALUE_BITS_DEF = 24;
    localparam int OUT_MAX_DEF    = 100;

    // Register file layout
    localparam int REG_INDEX_W     = 3;
    localparam int GAIN_W          = 16;
    localparam int IMAX_W          = 31;
    localparam int SUM_W           = 32;
    localparam int FRAC_OUT        = 16;
    localparam int DEADBAND_RESET  = 128;

    typedef enum logic [REG_INDEX_W-1:0] {
        REG_SETPOINT     = 3'd0,
        REG_KP           = 3'd1,
        REG_KI           = 3'd2,
        REG_KD           = 3'd3,
        REG_INTEGRAL_MAX = 3'd4,
        REG_DEADBAND     = 3'd5,
        REG_REVERSE      = 3'd6,
        REG_HOLD         = 3'd7
    } ppid_reg_t;

    // Gains and mode bits; setpoint travels separately (its width follows VALUE_BITS)
    typedef struct packed {
        logic [GAIN_W-1:0] kp;
        logic [GAIN_W-1:0] ki;
        logic [GAIN_W-1:0] kd;
        logic [IMAX_W-1:0] integral_max;
        logic [GAIN_W-1:0] deadband;
        logic              reverse_one_sided;
        logic              hold_in_band;
    } ppid_cfg_t;

    // Per-beat flags carried down the pipeline
    typedef struct packed {
        logic in_band;
        logic zero_out;
    } ppid_flags_t;

endpackage

>>> sv/ppid_cfg_regs.sv
module ppid_cfg_regs #(
    parameter int VALUE_BITS = ppid_pkg::VALUE_BITS_DEF,
    parameter int CFG_W      = (VALUE_BITS > ppid_pkg::IMAX_W) ? VALUE_BITS : ppid_pkg::IMAX_W
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [ppid_pkg::REG_INDEX_W-1:0]   cfg_addr,
    input  logic [CFG_W-1:0]                   cfg_wdata,
    output logic signed [VALUE_BITS-1:0]       setpoint,
    output ppid_pkg::ppid_cfg_t                cfg
);
    import ppid_pkg::*;

    logic signed [VALUE_BITS-1:0] setpoint_reg;
    ppid_cfg_t                    cfg_reg;

    // Register writes, no read-back
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            setpoint_reg              <= '0;
            cfg_reg.kp                <= '0;
            cfg_reg.ki                <= '0;
            cfg_reg.kd                <= '0;
            cfg_reg.integral_max      <= '0;
            cfg_reg.deadband          <= GAIN_W'(DEADBAND_RESET);
            cfg_reg.reverse_one_sided <= 1'b0;
            cfg_reg.hold_in_band      <= 1'b1;
        end else if (cfg_we) begin
            unique case (ppid_reg_t'(cfg_addr))
                REG_SETPOINT:     setpoint_reg              <= cfg_wdata[VALUE_BITS-1:0];
                REG_KP:           cfg_reg.kp                <= cfg_wdata[GAIN_W-1:0];
                REG_KI:           cfg_reg.ki                <= cfg_wdata[GAIN_W-1:0];
                REG_KD:           cfg_reg.kd                <= cfg_wdata[GAIN_W-1:0];
                REG_INTEGRAL_MAX: cfg_reg.integral_max      <= cfg_wdata[IMAX_W-1:0];
                REG_DEADBAND:     cfg_reg.deadband          <= cfg_wdata[GAIN_W-1:0];
                REG_REVERSE:      cfg_reg.reverse_one_sided <= cfg_wdata[0];
                REG_HOLD:         cfg_reg.hold_in_band      <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign setpoint = setpoint_reg;
    assign cfg      = cfg_reg;

endmodule

>>> sv/ppid_err_stage.sv
module ppid_err_stage #(
    parameter int VALUE_BITS = ppid_pkg::VALUE_BITS_DEF,
    parameter int EW         = VALUE_BITS + 1
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  ppid_pkg::ppid_cfg_t            cfg,
    input  logic signed [VALUE_BITS-1:0]   setpoint,
    // measurement beat
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [VALUE_BITS-1:0]   in_meas,
    // error, clamped integral, derivative difference
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [EW-1:0]           out_err,
    output logic signed [ppid_pkg::SUM_W-1:0] out_sum,
    output logic signed [EW:0]             out_diff,
    output ppid_pkg::ppid_flags_t          out_flags
);
    import ppid_pkg::*;

    // Compare width covers both the error and the 16-bit deadband
    localparam int CW = ((EW > GAIN_W + 1) ? EW : GAIN_W + 1) + 1;
    localparam int SW = ((EW > SUM_W) ? EW : SUM_W) + 1;

    localparam logic signed [SW-1:0] S32_MAX = {{(SW-SUM_W+1){1'b0}}, {(SUM_W-1){1'b1}}};
    localparam logic signed [SW-1:0] S32_MIN = {{(SW-SUM_W+1){1'b1}}, {(SUM_W-1){1'b0}}};

    // Input register
    logic                         a_valid_reg;
    logic signed [VALUE_BITS-1:0] a_meas_reg;

    // Loop state
    logic signed [SUM_W-1:0] error_sum_reg, error_sum_next;
    logic signed [EW-1:0]    prev_err_reg, prev_err_next;

    // Output register
    logic                    b_valid_reg;
    logic signed [EW-1:0]    b_err_reg, b_err_next;
    logic signed [SUM_W-1:0] b_sum_reg;
    logic signed [EW:0]      b_diff_reg, b_diff_next;
    ppid_flags_t             b_flags_reg, b_flags_next;

    logic b_ready, a_move;

    assign b_ready  = !b_valid_reg || out_ready;
    assign in_ready = !a_valid_reg || b_ready;
    assign a_move   = a_valid_reg && b_ready;

    // Error, band tests, integral update
    always_comb begin
        logic signed [EW-1:0] sp_x, meas_x;
        logic signed [CW-1:0] e_c, db_c;
        logic signed [SW-1:0] sum_raw;
        logic signed [SUM_W-1:0] sum_sat, sum_band;
        logic signed [SUM_W-1:0] imax_s;
        logic band, strict, hold;

        sp_x   = {setpoint[VALUE_BITS-1], setpoint};
        meas_x = {a_meas_reg[VALUE_BITS-1], a_meas_reg};
        if (cfg.reverse_one_sided) begin
            b_err_next = meas_x - sp_x;
        end else begin
            b_err_next = sp_x - meas_x;
        end

        e_c  = CW'(b_err_next);
        db_c = CW'($signed({1'b0, cfg.deadband}));
        if (cfg.reverse_one_sided) begin
            band = (e_c <= db_c);
        end else begin
            band = (e_c >= -db_c) && (e_c <= db_c);
        end
        strict = (e_c > -db_c) && (e_c < db_c);
        hold   = band && cfg.hold_in_band;

        // Saturating add to 32 bits, cleared inside the band
        sum_raw = SW'(error_sum_reg) + SW'(b_err_next);
        if (sum_raw > S32_MAX) begin
            sum_sat = S32_MAX[SUM_W-1:0];
        end else if (sum_raw < S32_MIN) begin
            sum_sat = S32_MIN[SUM_W-1:0];
        end else begin
            sum_sat = sum_raw[SUM_W-1:0];
        end
        sum_band = band ? '0 : sum_sat;

        // Clamp to 0..integral_max when ki is in use
        imax_s         = $signed({1'b0, cfg.integral_max});
        error_sum_next = sum_band;
        if (cfg.ki != '0) begin
            if (sum_band < 0) begin
                error_sum_next = '0;
            end else if (sum_band > imax_s) begin
                error_sum_next = imax_s;
            end
        end

        prev_err_next        = hold ? prev_err_reg : b_err_next;
        b_diff_next          = (EW+1)'(b_err_next) - (EW+1)'(prev_err_reg);
        b_flags_next.in_band  = band;
        b_flags_next.zero_out = hold || strict;
    end

    // Control and state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            error_sum_reg <= '0;
            prev_err_reg  <= '0;
        end else begin
            if (in_ready) begin
                a_valid_reg <= in_valid;
            end
            if (b_ready) begin
                b_valid_reg <= a_valid_reg;
            end
            if (a_move) begin
                error_sum_reg <= error_sum_next;
                prev_err_reg  <= prev_err_next;
            end
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            a_meas_reg <= in_meas;
        end
        if (a_move) begin
            b_err_reg   <= b_err_next;
            b_sum_reg   <= error_sum_next;
            b_diff_reg  <= b_diff_next;
            b_flags_reg <= b_flags_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_err   = b_err_reg;
    assign out_sum   = b_sum_reg;
    assign out_diff  = b_diff_reg;
    assign out_flags = b_flags_reg;

endmodule

>>> sv/ppid_mul_stage.sv
module ppid_mul_stage #(
    parameter int VALUE_BITS = ppid_pkg::VALUE_BITS_DEF,
    parameter int EW         = VALUE_BITS + 1,
    parameter int PW_P       = ppid_pkg::GAIN_W + 1 + EW,
    parameter int PW_I       = ppid_pkg::GAIN_W + 1 + ppid_pkg::SUM_W,
    parameter int PW_D       = ppid_pkg::GAIN_W + 2 + EW
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  ppid_pkg::ppid_cfg_t               cfg,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [EW-1:0]              in_err,
    input  logic signed [ppid_pkg::SUM_W-1:0] in_sum,
    input  logic signed [EW:0]                in_diff,
    input  ppid_pkg::ppid_flags_t             in_flags,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [PW_P-1:0]            out_p,
    output logic signed [PW_I-1:0]            out_i,
    output logic signed [PW_D-1:0]            out_d,
    output ppid_pkg::ppid_flags_t             out_flags
);
    import ppid_pkg::*;

    logic                  valid_reg;
    logic signed [PW_P-1:0] p_reg;
    logic signed [PW_I-1:0] i_reg;
    logic signed [PW_D-1:0] d_reg;
    ppid_flags_t           flags_reg;

    logic signed [GAIN_W:0] kp_s, ki_s, kd_s;
    logic signed [PW_P-1:0] p_next;
    logic signed [PW_I-1:0] i_next;
    logic signed [PW_D-1:0] d_next;

    assign in_ready = !valid_reg || out_ready;

    // Three independent gain products
    assign kp_s   = $signed({1'b0, cfg.kp});
    assign ki_s   = $signed({1'b0, cfg.ki});
    assign kd_s   = $signed({1'b0, cfg.kd});
    assign p_next = PW_P'(kp_s) * PW_P'(in_err);
    assign i_next = PW_I'(ki_s) * PW_I'(in_sum);
    assign d_next = PW_D'(kd_s) * PW_D'(in_diff);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            p_reg     <= p_next;
            i_reg     <= i_next;
            d_reg     <= d_next;
            flags_reg <= in_flags;
        end
    end

    assign out_valid = valid_reg;
    assign out_p     = p_reg;
    assign out_i     = i_reg;
    assign out_d     = d_reg;
    assign out_flags = flags_reg;

endmodule

>>> sv/ppid_out_stage.sv
module ppid_out_stage #(
    parameter int OUT_MAX = ppid_pkg::OUT_MAX_DEF,
    parameter int DRIVE_W = $clog2(OUT_MAX + 1),
    parameter int PW_P    = 42,
    parameter int PW_I    = 49,
    parameter int PW_D    = 43
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic signed [PW_P-1:0] in_p,
    input  logic signed [PW_I-1:0] in_i,
    input  logic signed [PW_D-1:0] in_d,
    input  ppid_pkg::ppid_flags_t  in_flags,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [DRIVE_W-1:0]     out_drive,
    output logic                   out_in_band
);
    import ppid_pkg::*;

    localparam int PW_PD = (PW_P > PW_D) ? PW_P : PW_D;
    localparam int PW_M  = (PW_PD > PW_I) ? PW_PD : PW_I;
    localparam int AW    = ((PW_M > FRAC_OUT + DRIVE_W + 1) ? PW_M : FRAC_OUT + DRIVE_W + 1) + 2;

    localparam logic signed [AW-1:0] OUT_LIM = AW'(OUT_MAX) <<< FRAC_OUT;
    localparam logic [DRIVE_W-1:0]   DRIVE_MAX = DRIVE_W'(OUT_MAX);

    logic               valid_reg;
    logic [DRIVE_W-1:0] drive_reg;
    logic               in_band_reg;

    logic signed [AW-1:0] acc;
    logic [DRIVE_W-1:0]   drive_next;

    assign in_ready = !valid_reg || out_ready;

    // Sum of terms, clamp to 0..OUT_MAX (zero when zero_out is set), truncate the Q.16 fraction
    always_comb begin
        acc = AW'(in_p) + AW'(in_i) + AW'(in_d);
        if (in_flags.zero_out) begin
            drive_next = '0;
        end else if (acc >= OUT_LIM) begin
            drive_next = DRIVE_MAX;
        end else if (acc <= 0) begin
            drive_next = '0;
        end else begin
            drive_next = acc[FRAC_OUT +: DRIVE_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            drive_reg   <= drive_next;
            in_band_reg <= in_flags.in_band;
        end
    end

    assign out_valid   = valid_reg;
    assign out_drive   = drive_reg;
    assign out_in_band = in_band_reg;

endmodule

>>> sv/positional_pid_with_deadband.sv
// Positional PID controller with error deadband, one drive beat per measurement beat.
//
// Channels: the s_ stream carries one signed Q.8 measurement per beat; the m_
// stream returns the drive (integer 0..OUT_MAX) in m_tdata and the in-band flag
// in m_tuser. The cfg_ write port sets setpoint, gains, integral clamp, deadband
// and the mode bits; write it only while no beats are in flight.
//
// Pipeline: four register stages (input, error/integral, products, result) lie
// between the edge that accepts the measurement and the rise of m_tvalid.
// Throughput: one beat per cycle while m_tready stays high. The error sum and last
// error close their loop in the error/integral stage, which sets that figure.
//
// Reset (aresetn low, synchronous): pipeline emptied, error sum and last error
// cleared, registers back to defaults (deadband 0.5, hold inside band on).
// Stall: when m_tready is low the result stays in the output register; earlier
// stages keep filling until every stage is occupied, then s_tready drops.
module positional_pid_with_deadband #(
    parameter int VALUE_BITS = ppid_pkg::VALUE_BITS_DEF,
    parameter int OUT_MAX    = ppid_pkg::OUT_MAX_DEF,
    parameter int DRIVE_W    = $clog2(OUT_MAX + 1),
    parameter int CFG_W      = (VALUE_BITS > ppid_pkg::IMAX_W) ? VALUE_BITS : ppid_pkg::IMAX_W,
    parameter int S_TDATA_W  = ((VALUE_BITS + 7) / 8) * 8,
    parameter int M_TDATA_W  = ((DRIVE_W + 7) / 8) * 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration writes
    input  logic                             cfg_we,
    input  logic [ppid_pkg::REG_INDEX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]                 cfg_wdata,
    // measurement stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [S_TDATA_W-1:0]             s_tdata,  // measurement
    // drive stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [M_TDATA_W-1:0]             m_tdata,  // drive
    output logic                             m_tuser   // in_band
);
    import ppid_pkg::*;

    localparam int EW   = VALUE_BITS + 1;
    localparam int PW_P = GAIN_W + 1 + EW;
    localparam int PW_I = GAIN_W + 1 + SUM_W;
    localparam int PW_D = GAIN_W + 2 + EW;

    ppid_cfg_t                    cfg;
    logic signed [VALUE_BITS-1:0] setpoint;

    logic                    e_valid, e_ready;
    logic signed [EW-1:0]    e_err;
    logic signed [SUM_W-1:0] e_sum;
    logic signed [EW:0]      e_diff;
    ppid_flags_t             e_flags;

    logic                   p_valid, p_ready;
    logic signed [PW_P-1:0] p_p;
    logic signed [PW_I-1:0] p_i;
    logic signed [PW_D-1:0] p_d;
    ppid_flags_t            p_flags;

    logic [DRIVE_W-1:0] drive;

    ppid_cfg_regs #(
        .VALUE_BITS (VALUE_BITS),
        .CFG_W      (CFG_W)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .setpoint  (setpoint),
        .cfg       (cfg)
    );

    ppid_err_stage #(
        .VALUE_BITS (VALUE_BITS),
        .EW         (EW)
    ) u_err (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .setpoint  (setpoint),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_meas   ($signed(s_tdata[VALUE_BITS-1:0])),
        .out_valid (e_valid),
        .out_ready (e_ready),
        .out_err   (e_err),
        .out_sum   (e_sum),
        .out_diff  (e_diff),
        .out_flags (e_flags)
    );

    ppid_mul_stage #(
        .VALUE_BITS (VALUE_BITS),
        .EW         (EW),
        .PW_P       (PW_P),
        .PW_I       (PW_I),
        .PW_D       (PW_D)
    ) u_mul (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (e_valid),
        .in_ready  (e_ready),
        .in_err    (e_err),
        .in_sum    (e_sum),
        .in_diff   (e_diff),
        .in_flags  (e_flags),
        .out_valid (p_valid),
        .out_ready (p_ready),
        .out_p     (p_p),
        .out_i     (p_i),
        .out_d     (p_d),
        .out_flags (p_flags)
    );

    ppid_out_stage #(
        .OUT_MAX (OUT_MAX),
        .DRIVE_W (DRIVE_W),
        .PW_P    (PW_P),
        .PW_I    (PW_I),
        .PW_D    (PW_D)
    ) u_out (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (p_valid),
        .in_ready    (p_ready),
        .in_p        (p_p),
        .in_i        (p_i),
        .in_d        (p_d),
        .in_flags    (p_flags),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_drive   (drive),
        .out_in_band (m_tuser)
    );

    assign m_tdata = M_TDATA_W'(drive);

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import ppid_pkg::*;

    localparam int VB          = VALUE_BITS_DEF;
    localparam int CW          = IMAX_W;         // config data width for the default build
    localparam int DRAIN_TAIL  = 6;              // cycles past the last drive beat
    localparam int STALL_LIMIT = 2000;
    localparam longint SUM_HI  = 64'sd2147483647;
    localparam longint SUM_LO  = -64'sd2147483648;

    // One drive beat as seen on the m_ side
    typedef struct packed {
        logic [6:0] drive;
        logic       in_band;
    } drive_beat_t;

    // Directed stimulus row: either a register write or a measurement beat
    typedef struct {
        bit          is_write;
        ppid_reg_t   idx;
        logic [30:0] val;
        logic [23:0] meas;
        bit          fixed;
        drive_beat_t result;
    } plan_row_t;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   cfg_we;
    logic [REG_INDEX_W-1:0] cfg_addr;
    logic [CW-1:0]          cfg_wdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [23:0]            s_tdata;   // measurement
    logic                   m_tvalid;
    logic                   m_tready;
    logic [7:0]             m_tdata;   // drive
    logic                   m_tuser;   // in_band

    positional_pid_with_deadband uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Controller shadow: registers and loop state
    logic [VB-1:0]        sp_q;
    logic [15:0]          kp_q, ki_q, kd_q, db_q;
    logic [30:0]          imax_q;
    logic                 rev_q, hold_q;
    logic signed [31:0]   err_sum_q;
    logic signed [24:0]   last_err_q;

    drive_beat_t expected_q[$];
    plan_row_t   plan[$];
    int          mismatches = 0;
    int          idle_pct   = 32;
    int          stall_cycles = 0;
    int          err_dir    = 1;
    bit          windup     = 1'b0;

    function automatic void reset_shadow();
        sp_q       = '0;
        kp_q       = '0;
        ki_q       = '0;
        kd_q       = '0;
        imax_q     = '0;
        db_q       = 16'(DEADBAND_RESET);
        rev_q      = 1'b0;
        hold_q     = 1'b1;
        err_sum_q  = '0;
        last_err_q = '0;
    endfunction

    // Next drive beat for one measurement; advances the loop state
    function automatic drive_beat_t predict_drive(logic [23:0] meas_raw);
        longint sp, meas, db, err, sum, acc;
        bit band, strict;
        drive_beat_t r;
        sp   = longint'($signed(sp_q));
        meas = longint'($signed(meas_raw));
        db   = longint'(db_q);
        if (rev_q) begin
            err  = meas - sp;
            band = (err <= db);
        end else begin
            err  = sp - meas;
            band = (err >= -db) && (err <= db);
        end
        strict = (err > -db) && (err < db);

        // integrator: cleared inside the band, saturating outside
        if (band) begin
            sum = 0;
        end else begin
            sum = longint'(err_sum_q) + err;
            if (sum > SUM_HI) sum = SUM_HI;
            if (sum < SUM_LO) sum = SUM_LO;
        end

        // hold: early zero, last error kept
        if (band && hold_q) begin
            err_sum_q = 32'(sum);
            r.drive   = '0;
            r.in_band = 1'b1;
            return r;
        end

        if (ki_q != 0) begin
            if (sum > longint'(imax_q)) sum = longint'(imax_q);
            if (sum < 0) sum = 0;
        end
        err_sum_q = 32'(sum);

        acc = longint'(kp_q) * err + longint'(ki_q) * sum
            + longint'(kd_q) * (err - longint'(last_err_q));
        last_err_q = 25'(err);

        if (acc >= (longint'(OUT_MAX_DEF) << FRAC_OUT)) r.drive = 7'(OUT_MAX_DEF);
        else if (acc <= 0)                            r.drive = '0;
        else                                          r.drive = 7'(acc >>> FRAC_OUT);
        if (strict) r.drive = '0;
        r.in_band = band;
        return r;
    endfunction

    // One register write, driven at the edge; caller lowers cfg_we after a batch
    task automatic write_reg(input ppid_reg_t idx, input logic [30:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_SETPOINT:     sp_q   = val[VB-1:0];
            REG_KP:           kp_q   = val[15:0];
            REG_KI:           ki_q   = val[15:0];
            REG_KD:           kd_q   = val[15:0];
            REG_INTEGRAL_MAX: imax_q = val;
            REG_DEADBAND:     db_q   = val[15:0];
            REG_REVERSE:      rev_q  = val[0];
            REG_HOLD:         hold_q = val[0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // Stop sending, let every drive beat come back, then the pipeline tail
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_TAIL) @(posedge aclk);
    endtask

    // Send one measurement beat; queue its predicted (or fixed) drive beat
    task automatic send_meas(input logic [23:0] m, input bit fixed,
                             input drive_beat_t fixed_val);
        drive_beat_t p;
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= m;
        do @(posedge aclk); while (!s_tready);
        p = predict_drive(m);
        if (fixed) p = fixed_val;
        expected_q.push_back(p);
    endtask

    function automatic void add_write(ppid_reg_t idx, logic [30:0] val);
        plan_row_t row;
        row          = '{idx: REG_SETPOINT, default: '0};
        row.is_write = 1'b1;
        row.idx      = idx;
        row.val      = val;
        plan.push_back(row);
    endfunction

    function automatic void add_meas(logic [23:0] m, bit fixed, logic [6:0] d, logic b);
        plan_row_t row;
        row        = '{idx: REG_SETPOINT, default: '0};
        row.idx    = REG_SETPOINT;
        row.meas   = m;
        row.fixed  = fixed;
        row.result = {d, b};
        plan.push_back(row);
    endfunction

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(3))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(1, 1024));
            default: return 16'($urandom);
        endcase
    endfunction

    // Measurement that lands near the band edges, far out, or drifts one way
    function automatic logic [23:0] pick_meas();
        longint sp, db, err;
        sp = longint'($signed(sp_q));
        db = longint'(db_q);
        if (windup) return (err_dir > 0) ? 24'h800000 : 24'h7FFFFF;
        case ($urandom_range(9))
            0: return 24'($urandom);
            1: return $urandom_range(1) ? 24'h800000 : 24'h7FFFFF;
            2, 3, 4: begin
                case ($urandom_range(6))
                    0:       err = -db - 1;
                    1:       err = -db;
                    2:       err = -db + 1;
                    3:       err = db - 1;
                    4:       err = db;
                    5:       err = db + 1;
                    default: err = 0;
                endcase
            end
            5:       err = -err_dir * longint'($urandom_range(1, 3000));
            6:       err = err_dir * longint'($urandom_range(0, 8388607));
            default: err = err_dir * longint'($urandom_range(1, 30000));
        endcase
        return 24'(rev_q ? sp + err : sp - err);
    endfunction

    // New random settings for a phase, written only once the pipeline is empty
    task automatic randomize_settings(input bit need_ki);
        logic [VB-1:0] sp;
        logic [15:0]   kp, ki, kd, db;
        logic [30:0]   imax;
        logic          rev, hold;
        int            sel;
        case ($urandom_range(4))
            0:       sp = 24'h800000;
            1:       sp = 24'h7FFFFF;
            2:       sp = '0;
            default: sp = 24'($urandom);
        endcase
        kp = pick_gain();
        ki = pick_gain();
        kd = pick_gain();
        if (need_ki && ki == 0) ki = 16'd256;
        case ($urandom_range(4))
            0:       db = 16'd0;
            1:       db = 16'hFFFF;
            2:       db = 16'(DEADBAND_RESET);
            3:       db = 16'($urandom_range(0, 2000));
            default: db = 16'($urandom);
        endcase
        rev  = 1'($urandom_range(1));
        hold = 1'($urandom_range(1));
        // wind the sum hard into one rail with the integral term off
        if (windup) begin
            rev = 1'b0;
            ki  = 16'd0;
            sp  = (err_dir > 0) ? 24'h7FFFFF : 24'h800000;
        end
        sel = $urandom_range(5);
        if (ki != 0 && sel < 2) imax = 31'((100 * 65536) / int'(ki));
        else if (sel == 2)      imax = '1;
        else if (sel == 3)      imax = '0;
        else                    imax = 31'($urandom);

        wait_drain();
        write_reg(REG_SETPOINT, 31'(sp));
        write_reg(REG_KP, 31'(kp));
        write_reg(REG_KI, 31'(ki));
        write_reg(REG_KD, 31'(kd));
        write_reg(REG_INTEGRAL_MAX, imax);
        write_reg(REG_DEADBAND, 31'(db));
        write_reg(REG_REVERSE, 31'(rev));
        write_reg(REG_HOLD, 31'(hold));
        cfg_we <= 1'b0;
    endtask

    // Drive beat checker; the random backpressure is driven by the loop below
    task automatic check_beat();
        drive_beat_t want;
        if (expected_q.size() == 0) begin
            $error("drive beat with no measurement pending: drive=%0d in_band=%0b",
                   m_tdata, m_tuser);
            mismatches++;
        end else begin
            want = expected_q.pop_front();
            if (m_tdata !== {1'b0, want.drive}) begin
                $error("drive: expected %0d, actual %0d", want.drive, m_tdata);
                mismatches++;
            end
            if (m_tuser !== want.in_band) begin
                $error("in_band: expected %0b, actual %0b", want.in_band, m_tuser);
                mismatches++;
            end
        end
    endtask

    initial begin
        forever begin
            @(posedge aclk);
            if (m_tvalid === 1'b1 && m_tready === 1'b1) check_beat();
            m_tready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // Watchdog: cycles without any beat on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        bit writing;
        int n_items;
        cfg_we    = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        aresetn   = 1'b0;
        writing   = 1'b0;
        reset_shadow();

        // Directed: defaults, band edges, gain and value extremes, both modes
        add_meas(24'd0, 1, 7'd0, 1'b1);          // zero error, hold at reset
        add_meas(24'hFFFF38, 1, 7'd0, 1'b0);     // out of band, all gains zero
        add_meas(24'd128, 1, 7'd0, 1'b1);        // exactly on the lower edge, held
        add_write(REG_KP, 31'hFFFF);
        add_write(REG_HOLD, 31'd0);
        add_meas(24'h800000, 1, 7'd100, 1'b0);   // largest error, full drive
        add_meas(24'h7FFFFF, 1, 7'd0, 1'b0);     // most negative error
        add_meas(24'hFFFF80, 1, 7'd100, 1'b1);   // on the edge: in band, not forced
        add_meas(24'hFFFF81, 1, 7'd0, 1'b1);     // strictly inside: forced zero
        add_write(REG_SETPOINT, 31'd1000);
        add_write(REG_KP, 31'd256);
        add_write(REG_KI, 31'd256);
        add_write(REG_KD, 31'd512);
        add_write(REG_INTEGRAL_MAX, 31'd25600);
        add_write(REG_DEADBAND, 31'd64);
        add_meas(24'd0, 0, '0, 1'b0);
        add_meas(24'hFFF830, 0, '0, 1'b0);
        add_meas(24'd990, 0, '0, 1'b0);
        add_meas(24'hFF8AD0, 0, '0, 1'b0);      // sum runs into its clamp
        add_meas(24'd5000, 0, '0, 1'b0);
        add_write(REG_REVERSE, 31'd1);
        add_write(REG_DEADBAND, 31'd0);
        add_write(REG_HOLD, 31'd1);
        add_meas(24'd1000, 1, 7'd0, 1'b1);       // one-sided, zero error
        add_meas(24'd0, 1, 7'd0, 1'b1);          // one-sided, far below
        add_meas(24'd1001, 0, '0, 1'b0);
        add_meas(24'h7FFFFF, 0, '0, 1'b0);
        add_write(REG_HOLD, 31'd0);
        add_write(REG_DEADBAND, 31'hFFFF);
        add_write(REG_KI, 31'hFFFF);
        add_write(REG_KD, 31'hFFFF);
        add_write(REG_INTEGRAL_MAX, 31'h7FFFFFFF);
        add_write(REG_SETPOINT, 31'h800000);
        add_meas(24'h7FFFFF, 0, '0, 1'b0);       // widest error of all
        add_meas(24'h800000, 1, 7'd0, 1'b1);     // zero error, wide band
        add_write(REG_SETPOINT, 31'h7FFFFF);
        add_write(REG_REVERSE, 31'd0);
        add_meas(24'h800000, 0, '0, 1'b0);
        add_meas(24'h7FFFFF, 1, 7'd0, 1'b1);
        add_meas(24'd0, 0, '0, 1'b0);

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].is_write) begin
                if (!writing) begin
                    wait_drain();
                    writing = 1'b1;
                end
                write_reg(plan[i].idx, plan[i].val);
            end else begin
                if (writing) begin
                    cfg_we  <= 1'b0;
                    writing = 1'b0;
                end
                send_meas(plan[i].meas, plan[i].fixed, plan[i].result);
            end
        end

        // Random phases; one winds the sum into a rail, the next turns ki on
        for (int p = 0; p < 10; p++) begin
            windup  = (p == 4);
            err_dir = $urandom_range(1) ? 1 : -1;
            randomize_settings(p == 5);
            idle_pct = (p == 1) ? 0 : 32;
            n_items  = windup ? 160 : 38;
            for (int k = 0; k < n_items; k++) begin
                if (p == 6 && k == n_items / 2) wait_drain();
                send_meas(pick_meas(), 1'b0, '0);
            end
        end
        windup = 1'b0;
        wait_drain();

        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
